### sv/chacha20_stream_cipher_assert.svh
// Assertion macros for the ChaCha20 stream cipher.
`ifndef CHACHA20_STREAM_CIPHER_ASSERT_SVH
`define CHACHA20_STREAM_CIPHER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset
`define CHACHA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("chacha assertion failed");
// Next-cycle implication, checked out of reset
`define CHACHA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("chacha assertion failed");
`else
`define CHACHA_ASSERT_IMP(label, ante, cons)
`define CHACHA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### sv/chacha_pkg.sv
// Shared types and constants of the ChaCha20 stream cipher.
`timescale 1ns / 1ps
package chacha_pkg;

    // Bytes one word may carry, and the saturation limit of its count
    localparam int BYTES_PER_ITEM = 8;
    localparam int ITEM_LIMIT = (BYTES_PER_ITEM < 8) ? BYTES_PER_ITEM : 8;
    localparam logic [3:0] COUNT_MAX = 4'(ITEM_LIMIT);

    // Keystream block size in bytes; a position of this value means used up
    localparam logic [6:0] BLOCK_BYTES = 7'd64;

    // Half quarter rounds per block: ten double rounds, four steps each
    localparam logic [5:0] ROUND_STEPS = 6'd40;

    // "expand 32-byte k"
    localparam logic [31:0] SIGMA0 = 32'h6170_7865;
    localparam logic [31:0] SIGMA1 = 32'h3320_646e;
    localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
    localparam logic [31:0] SIGMA3 = 32'h6b20_6574;

    // Configuration register indexes
    localparam logic [2:0] REG_KEY0     = 3'd0;
    localparam logic [2:0] REG_KEY1     = 3'd1;
    localparam logic [2:0] REG_KEY2     = 3'd2;
    localparam logic [2:0] REG_KEY3     = 3'd3;
    localparam logic [2:0] REG_NONCE_LO = 3'd4;
    localparam logic [2:0] REG_NONCE_HI = 3'd5;

    // Sixteen 32-bit words of state or keystream, word 0 lowest
    typedef logic [15:0][31:0] blk_t;

    // Key as four 64-bit quarters of register writes
    typedef logic [3:0][63:0] key_t;

    // Block request to the core
    typedef struct packed {
        logic        start;
        logic [31:0] counter;
    } core_req_t;

    // Core status back to the controller
    typedef struct packed {
        logic busy;
        logic done;
    } core_stat_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_GEN
    } ctrl_state_t;

endpackage

### sv/chacha_lane.sv
// One quarter-round lane: computes either half of a ChaCha quarter round.
`timescale 1ns / 1ps
module chacha_lane
    import chacha_pkg::*;
(
    input  logic        second_half,
    input  logic [31:0] a,
    input  logic [31:0] b,
    input  logic [31:0] c,
    input  logic [31:0] d,
    output logic [31:0] a_out,
    output logic [31:0] b_out,
    output logic [31:0] c_out,
    output logic [31:0] d_out
);

    function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
        begin
            rotl = (v << n) | (v >> (32 - n));
        end
    endfunction

    logic [31:0] a_sum;
    logic [31:0] c_sum;
    logic [31:0] d_mix;

    // Two add-xor-rotate steps; rotation amounts depend on the half
    always_comb
    begin
        a_sum = a + b;
        if (second_half)
        begin
            d_mix = rotl(d ^ a_sum, 8);
            c_sum = c + d_mix;
            b_out = rotl(b ^ c_sum, 7);
        end
        else
        begin
            d_mix = rotl(d ^ a_sum, 16);
            c_sum = c + d_mix;
            b_out = rotl(b ^ c_sum, 12);
        end
        a_out = a_sum;
        c_out = c_sum;
        d_out = d_mix;
    end

endmodule

### sv/chacha_core.sv
// ChaCha20 block function: four lanes in parallel, then the feed-forward add.
`timescale 1ns / 1ps
module chacha_core
    import chacha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  key_t        key,
    input  logic [63:0] nonce_lo,
    input  logic [31:0] nonce_hi,
    input  core_req_t   req,
    output core_stat_t  stat,
    output blk_t        blk
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  step_reg, step_next;
    logic [31:0] ctr_init_reg, ctr_init_next;
    blk_t        w_reg, w_next;
    blk_t        blk_reg, blk_next;

    logic        diag;
    logic        second_half;
    logic [31:0] la [4];
    logic [31:0] lb [4];
    logic [31:0] lc [4];
    logic [31:0] ld [4];
    logic [31:0] ra [4];
    logic [31:0] rb [4];
    logic [31:0] rc [4];
    logic [31:0] rd [4];
    blk_t        init_start;
    blk_t        init_run;

    function automatic blk_t build_init(input key_t k, input logic [63:0] nlo,
                                        input logic [31:0] nhi, input logic [31:0] ctr);
        blk_t s;
        begin
            s[0] = SIGMA0;
            s[1] = SIGMA1;
            s[2] = SIGMA2;
            s[3] = SIGMA3;
            for (int i = 0; i < 4; i++)
            begin
                s[4 + 2 * i] = k[i][31:0];
                s[5 + 2 * i] = k[i][63:32];
            end
            s[12] = ctr;
            s[13] = nlo[31:0];
            s[14] = nlo[63:32];
            s[15] = nhi;
            build_init = s;
        end
    endfunction

    // Key and nonce must hold steady while a block is made; the core does not enforce it
    assign init_start = build_init(key, nonce_lo, nonce_hi, req.counter);
    assign init_run   = build_init(key, nonce_lo, nonce_hi, ctr_init_reg);

    // Step order: column first half, column second half, diagonal halves
    assign second_half = step_reg[0];
    assign diag        = step_reg[1];

    // Gather lane operands: columns, or diagonals
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            la[k] = w_reg[k];
            if (diag)
            begin
                lb[k] = w_reg[4 + ((k + 1) & 3)];
                lc[k] = w_reg[8 + ((k + 2) & 3)];
                ld[k] = w_reg[12 + ((k + 3) & 3)];
            end
            else
            begin
                lb[k] = w_reg[4 + k];
                lc[k] = w_reg[8 + k];
                ld[k] = w_reg[12 + k];
            end
        end
    end

    for (genvar g = 0; g < 4; g++)
    begin : g_lane
        chacha_lane u_lane (
            .second_half (second_half),
            .a           (la[g]),
            .b           (lb[g]),
            .c           (lc[g]),
            .d           (ld[g]),
            .a_out       (ra[g]),
            .b_out       (rb[g]),
            .c_out       (rc[g]),
            .d_out       (rd[g])
        );
    end

    // Sequencing, scatter of lane results and feed-forward merge
    always_comb
    begin
        busy_next     = busy_reg;
        done_next     = 1'b0;
        step_next     = step_reg;
        ctr_init_next = ctr_init_reg;
        w_next        = w_reg;
        blk_next      = blk_reg;
        if (!busy_reg)
        begin
            if (req.start)
            begin
                busy_next     = 1'b1;
                step_next     = '0;
                ctr_init_next = req.counter;
                w_next        = init_start;
            end
        end
        else if (step_reg != ROUND_STEPS)
        begin
            for (int k = 0; k < 4; k++)
            begin
                w_next[k] = ra[k];
                if (diag)
                begin
                    w_next[4 + ((k + 1) & 3)]  = rb[k];
                    w_next[8 + ((k + 2) & 3)]  = rc[k];
                    w_next[12 + ((k + 3) & 3)] = rd[k];
                end
                else
                begin
                    w_next[4 + k]  = rb[k];
                    w_next[8 + k]  = rc[k];
                    w_next[12 + k] = rd[k];
                end
            end
            step_next = step_reg + 6'd1;
        end
        else
        begin
            for (int i = 0; i < 16; i++)
            begin
                blk_next[i] = w_reg[i] + init_run[i];
            end
            busy_next = 1'b0;
            done_next = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // Working state and result
    always_ff @(posedge clk)
    begin
        ctr_init_reg <= ctr_init_next;
        w_reg        <= w_next;
        blk_reg      <= blk_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign blk       = blk_reg;

endmodule

### sv/chacha20_stream_cipher.sv
// ChaCha20 stream cipher: top level with controller, keystream line and byte lanes.
//
// Input words on s_axis carry up to eight message bytes (byte i in bits 8i+7..8i),
// a byte count in the next nibble and a message-start flag in tuser. Each valid
// byte is XORed with the next keystream byte; bytes above the count come out zero.
// One result word per input word leaves on m_axis with the saturated byte count.
// Key and nonce are written through cfg_we/cfg_index/cfg_data; the user must write
// them only while the block is idle, which the block does not enforce; a write takes
// effect from the next keystream block. A word is accepted in the idle state, worked
// on in the run state and loaded into the output register when its bytes are done
// and that register is free; only then does it return to idle and take a new word.
// A fresh 64-byte block needs the request, four half-quarter-round lanes stepping 40
// times through ten double rounds, the feed-forward add and the keystream line load.
// Reset clears the key, nonce, block counter and forces a fresh block on the first
// byte. If m_axis stalls, one finished word waits in the output register while
// the next word is accepted and worked on; it then holds until the output frees.
`timescale 1ns / 1ps
`include "chacha20_stream_cipher_assert.svh"
module chacha20_stream_cipher
    import chacha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // config write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // [63:0] data_in, [67:64] byte_count, rest zero
    input  logic [0:0]  s_axis_tuser,   // [0] message_start
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata    // [63:0] data_out, [67:64] out_count, rest zero
);

    ctrl_state_t state_reg, state_next;
    key_t        key_reg;
    logic [63:0] nonce_lo_reg;
    logic [31:0] nonce_hi_reg;
    logic [31:0] ctr_reg, ctr_next;
    logic [6:0]  pos_reg, pos_next;
    logic [511:0] ks_reg, ks_next;
    logic [63:0] data_reg, data_next;
    logic [3:0]  count_reg, count_next;
    logic [3:0]  taken_reg, taken_next;
    logic [63:0] res_reg, res_next;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] out_data_reg, out_data_next;
    logic [3:0]  out_count_reg, out_count_next;

    core_req_t   core_req;
    core_stat_t  core_stat;
    blk_t        core_blk;

    logic        in_accept;
    logic [3:0]  in_count;
    logic [3:0]  remain;
    logic [6:0]  avail;
    logic [3:0]  n_take;
    logic [3:0]  taken_sum;
    logic        need_gen;
    logic [63:0] ks_low;
    logic [63:0] res_mix;
    logic        out_free;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg      <= '0;
            nonce_lo_reg <= '0;
            nonce_hi_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KEY0:     key_reg[0]   <= cfg_data;
                REG_KEY1:     key_reg[1]   <= cfg_data;
                REG_KEY2:     key_reg[2]   <= cfg_data;
                REG_KEY3:     key_reg[3]   <= cfg_data;
                REG_NONCE_LO: nonce_lo_reg <= cfg_data;
                REG_NONCE_HI: nonce_hi_reg <= cfg_data[31:0];
                default:      ;
            endcase
        end
    end

    chacha_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .key      (key_reg),
        .nonce_lo (nonce_lo_reg),
        .nonce_hi (nonce_hi_reg),
        .req      (core_req),
        .stat     (core_stat),
        .blk      (core_blk)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign in_count      = (s_axis_tdata[67:64] > COUNT_MAX) ? COUNT_MAX : s_axis_tdata[67:64];
    assign out_free      = !out_valid_reg || m_axis_tready;

    // Bytes this cycle can take from the current block
    assign remain    = count_reg - taken_reg;
    assign avail     = BLOCK_BYTES - pos_reg;
    assign n_take    = ({3'b000, remain} > avail) ? avail[3:0] : remain;
    assign taken_sum = taken_reg + n_take;
    assign need_gen  = (remain != 4'd0) && (pos_reg == BLOCK_BYTES);
    assign ks_low    = ks_reg[63:0];

    // Byte lanes: each output byte picks its keystream byte from the line head
    always_comb
    begin
        logic [3:0] j4;
        logic [3:0] rel;
        res_mix = res_reg;
        for (int j = 0; j < 8; j++)
        begin
            j4  = 4'(j);
            rel = j4 - taken_reg;
            if (j4 >= taken_reg && j4 < taken_sum)
            begin
                res_mix[8 * j +: 8] = data_reg[8 * j +: 8] ^ ks_low[{rel[2:0], 3'b000} +: 8];
            end
        end
    end

    // Controller
    always_comb
    begin
        state_next       = state_reg;
        ctr_next         = ctr_reg;
        pos_next         = pos_reg;
        ks_next          = ks_reg;
        data_next        = data_reg;
        count_next       = count_reg;
        taken_next       = taken_reg;
        res_next         = res_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        out_data_next    = out_data_reg;
        out_count_next   = out_count_reg;
        core_req.start   = 1'b0;
        core_req.counter = ctr_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    data_next  = s_axis_tdata[63:0];
                    count_next = in_count;
                    taken_next = '0;
                    res_next   = '0;
                    if (s_axis_tuser[0])
                    begin
                        ctr_next = '0;
                        pos_next = BLOCK_BYTES;
                    end
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (need_gen)
                begin
                    core_req.start = 1'b1;
                    ctr_next       = ctr_reg + 32'd1;
                    state_next     = ST_GEN;
                end
                else
                begin
                    taken_next = taken_sum;
                    res_next   = res_mix;
                    pos_next   = pos_reg + {3'b000, n_take};
                    ks_next    = ks_reg >> {n_take, 3'b000};
                    if (taken_sum == count_reg && out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = res_mix;
                        out_count_next = count_reg;
                        state_next     = ST_IDLE;
                    end
                end
            end
            ST_GEN:
            begin
                if (core_stat.done)
                begin
                    ks_next    = core_blk;
                    pos_next   = '0;
                    state_next = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ctr_reg       <= '0;
            pos_reg       <= BLOCK_BYTES;
            taken_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ctr_reg       <= ctr_next;
            pos_reg       <= pos_next;
            taken_reg     <= taken_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: keystream line, word under work, output register
    always_ff @(posedge clk)
    begin
        ks_reg        <= ks_next;
        data_reg      <= data_next;
        res_reg       <= res_next;
        out_data_reg  <= out_data_next;
        out_count_reg <= out_count_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_count_reg, out_data_reg};

    // While waiting for a block the core is working or has just finished
    `CHACHA_ASSERT_IMP(a_gen_core_active, state_reg == ST_GEN, core_stat.busy || core_stat.done)
    // A used-up block with bytes left always leads to block generation
    `CHACHA_ASSERT_NEXT(a_run_to_gen, state_reg == ST_RUN && need_gen, state_reg == ST_GEN)
    // A result only appears out of the processing state
    `CHACHA_ASSERT_IMP(a_out_from_run, $rose(out_valid_reg), $past(state_reg) == ST_RUN)
    // Bytes taken never pass the count of the word under work
    `CHACHA_ASSERT_IMP(a_taken_bound, state_reg == ST_RUN, taken_reg <= count_reg)

endmodule

### verif/tb_top.sv
// Testbench for the ChaCha20 stream cipher: directed and random words checked against a predictor.
`timescale 1ns / 1ps
module tb_top;
    import chacha_pkg::*;

    localparam int LIMIT_CYCLES   = 600000;
    localparam int DRAIN_CYCLES   = 64;     // fresh block plus pipeline, with margin
    localparam int RANDOM_PHASES  = 4;
    localparam int WORDS_PER_PHASE = 200;
    localparam int MAX_REPORTS    = 50;

    // Write indexes past the register list; the block must ignore them
    localparam logic [2:0] REG_SPARE6 = 3'd6;
    localparam logic [2:0] REG_SPARE7 = 3'd7;

    typedef struct {
        logic [63:0] data;
        logic [3:0]  count;
    } cipher_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;     // [63:0] data_in, [67:64] byte_count, rest zero
    logic [0:0]  s_axis_tuser = '0;     // [0] message_start
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;          // [63:0] data_out, [67:64] out_count, rest zero

    // Predictor state: registers, current block, counter and byte position
    key_t        m_key = '0;
    logic [63:0] m_nonce_lo = '0;
    logic [31:0] m_nonce_hi = '0;
    blk_t        m_block = '0;
    logic [31:0] m_ctr = '0;
    int          m_pos = 64;

    cipher_word_t pending_cipher_q[$];

    bit          in_idle = 1'b1;
    bit          out_idle = 1'b1;
    int          ready_hold = 0;
    int unsigned cycle_count = 0;
    int          err_count = 0;
    int          words_sent = 0;
    int          words_checked = 0;
    int          keyset_loads = 0;

    always #4 clk = ~clk;

    chacha20_stream_cipher DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // ---------------------------------------------------------------- predictor

    function automatic logic [31:0] rotl32(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic blk_t quarter_round(input blk_t w, input int a, input int b,
                                           input int c, input int d);
        w[a] = w[a] + w[b]; w[d] = rotl32(w[d] ^ w[a], 16);
        w[c] = w[c] + w[d]; w[b] = rotl32(w[b] ^ w[c], 12);
        w[a] = w[a] + w[b]; w[d] = rotl32(w[d] ^ w[a], 8);
        w[c] = w[c] + w[d]; w[b] = rotl32(w[b] ^ w[c], 7);
        return w;
    endfunction

    // One 64-byte keystream block: twenty rounds then the feed-forward add
    function automatic blk_t chacha_block(input key_t k, input logic [31:0] ctr,
                                          input logic [63:0] nlo, input logic [31:0] nhi);
        blk_t init_s;
        blk_t w;
        int   i;
        init_s[0] = SIGMA0;
        init_s[1] = SIGMA1;
        init_s[2] = SIGMA2;
        init_s[3] = SIGMA3;
        for (i = 0; i < 4; i++)
        begin
            init_s[4 + 2 * i] = k[i][31:0];
            init_s[5 + 2 * i] = k[i][63:32];
        end
        init_s[12] = ctr;
        init_s[13] = nlo[31:0];
        init_s[14] = nlo[63:32];
        init_s[15] = nhi;
        w = init_s;
        for (i = 0; i < 10; i++)
        begin
            w = quarter_round(w, 0, 4, 8, 12);
            w = quarter_round(w, 1, 5, 9, 13);
            w = quarter_round(w, 2, 6, 10, 14);
            w = quarter_round(w, 3, 7, 11, 15);
            w = quarter_round(w, 0, 5, 10, 15);
            w = quarter_round(w, 1, 6, 11, 12);
            w = quarter_round(w, 2, 7, 8, 13);
            w = quarter_round(w, 3, 4, 9, 14);
        end
        for (i = 0; i < 16; i++)
            w[i] = w[i] + init_s[i];
        return w;
    endfunction

    // Cipher word expected for one accepted input word
    function automatic void predict_cipher_word(input logic [63:0] data, input logic [3:0] cnt,
                                                input logic start);
        cipher_word_t exp_w;
        logic [3:0]   n;
        logic [31:0]  ks_word;
        int           i;
        n = (cnt > COUNT_MAX) ? COUNT_MAX : cnt;
        if (start)
        begin
            m_ctr = '0;
            m_pos = int'(BLOCK_BYTES);
        end
        exp_w.data  = '0;
        exp_w.count = n;
        for (i = 0; i < int'(n); i++)
        begin
            // block used up: make the next one, counter wraps naturally at 32 bits
            if (m_pos >= int'(BLOCK_BYTES))
            begin
                m_block = chacha_block(m_key, m_ctr, m_nonce_lo, m_nonce_hi);
                m_ctr   = m_ctr + 32'd1;
                m_pos   = 0;
            end
            ks_word = m_block[m_pos / 4];
            exp_w.data[8 * i +: 8] = data[8 * i +: 8] ^ ks_word[8 * (m_pos % 4) +: 8];
            m_pos++;
        end
        pending_cipher_q.push_back(exp_w);
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (err_count < MAX_REPORTS)
            $display("ERROR %0s: got %h, expected %h (result %0d, cycle %0d)",
                     what, got, want, words_checked, cycle_count);
        err_count++;
    endtask

    always @(posedge clk)
    begin : check_output
        cipher_word_t want;
        if (rst_n && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
        begin
            if (pending_cipher_q.size() == 0)
                report_mismatch("word with nothing expected", m_axis_tdata[63:0], '0);
            else
            begin
                want = pending_cipher_q.pop_front();
                if (m_axis_tdata[63:0] !== want.data)
                    report_mismatch("data_out", m_axis_tdata[63:0], want.data);
                if (m_axis_tdata[67:64] !== want.count)
                    report_mismatch("out_count", 64'(m_axis_tdata[67:64]), 64'(want.count));
                words_checked++;
            end
        end
    end

    // ---------------------------------------------------------------- idling

    // Mostly short gaps, a few long ones
    function automatic int pick_idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 93)
            return $urandom_range(4, 8);
        return $urandom_range(12, 40);
    endfunction

    // Output back-pressure
    always @(posedge clk)
    begin
        if (ready_hold > 0)
        begin
            ready_hold    <= ready_hold - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (out_idle && $urandom_range(0, 99) < 25)
                ready_hold <= pick_idle_len();
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_cipher_q.size());
            $display("Verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------- drivers

    // Sends one word, predicts its result, then maybe idles the input
    task automatic send_word(input logic [63:0] data, input logic [3:0] cnt, input logic start);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, cnt, data};
        s_axis_tuser  <= start;
        do
            @(posedge clk);
        while (s_axis_tready !== 1'b1);
        predict_cipher_word(data, cnt, start);
        words_sent++;
        gap = (in_idle && $urandom_range(0, 99) < 50) ? pick_idle_len() : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Waits for every expected word, then lets the block settle
    task automatic wait_cipher_drain();
        s_axis_tvalid <= 1'b0;
        while (pending_cipher_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: m_key[idx[1:0]] = value;
            REG_NONCE_LO: m_nonce_lo = value;
            REG_NONCE_HI: m_nonce_hi = value[31:0];
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_keyset(input key_t k, input logic [63:0] nlo, input logic [63:0] nhi);
        write_reg(REG_KEY0, k[0]);
        write_reg(REG_KEY1, k[1]);
        write_reg(REG_KEY2, k[2]);
        write_reg(REG_KEY3, k[3]);
        write_reg(REG_NONCE_LO, nlo);
        write_reg(REG_NONCE_HI, nhi);
        keyset_loads++;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // ---------------------------------------------------------------- tests

    // Zero key out of reset: first word makes a block without a start flag,
    // then empty, saturating and single-byte counts
    task automatic test_zero_key_counts();
        send_word('1, 4'd8, 1'b0);
        send_word(rand64(), 4'd0, 1'b0);
        send_word('1, 4'd15, 1'b0);
        send_word('0, 4'd9, 1'b0);
        send_word(rand64(), 4'd1, 1'b0);
        wait_cipher_drain();
    endtask

    // All-ones key and nonce; spare index written; block boundary inside a word
    task automatic test_extreme_keyset_boundary();
        load_keyset('1, '1, '1);
        write_reg(REG_SPARE6, rand64());
        send_word(rand64(), 4'd5, 1'b1);
        repeat (8) send_word(rand64(), 4'd8, 1'b0);
        wait_cipher_drain();
    endtask

    // A start flag mid-stream restarts the counter at zero
    task automatic test_message_restart();
        key_t k;
        k[0] = 64'h0706050403020100;
        k[1] = 64'h0f0e0d0c0b0a0908;
        k[2] = 64'h1716151413121110;
        k[3] = 64'h1f1e1d1c1b1a1918;
        load_keyset(k, 64'h4a000000_09000000, 64'hffffffff_00000000);
        send_word(rand64(), 4'd4, 1'b1);
        send_word(rand64(), 4'd8, 1'b0);
        send_word(rand64(), 4'd8, 1'b1);
        wait_cipher_drain();
    endtask

    // Key and nonce change mid-message: the held block stays, the next one uses them
    task automatic test_rekey_mid_message();
        send_word(rand64(), 4'd8, 1'b1);
        send_word(rand64(), 4'd8, 1'b0);
        wait_cipher_drain();
        write_reg(REG_KEY1, rand64());
        write_reg(REG_NONCE_HI, rand64());
        repeat (7) send_word(rand64(), 4'd8, 1'b0);
        wait_cipher_drain();
    endtask

    // Random messages under random keys, idling mode varied per phase
    task automatic test_random_messages();
        key_t        k;
        int          ph;
        int          j;
        int          len;
        int          sent;
        int          r;
        bit          carry_on;
        logic [3:0]  cnt;
        logic        start;
        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            in_idle  = ph[0];
            out_idle = ph[1];
            for (j = 0; j < 4; j++)
                k[j] = rand64();
            load_keyset(k, rand64(), rand64());
            if ($urandom_range(0, 1))
                write_reg(REG_SPARE7, rand64());
            // sometimes carry the previous message on under the new key
            carry_on = (ph > 0) && $urandom_range(0, 1);
            sent = 0;
            while (sent < WORDS_PER_PHASE)
            begin
                len = $urandom_range(1, 24);
                for (j = 0; j < len; j++)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 45)
                        cnt = 4'd8;
                    else if (r < 85)
                        cnt = 4'($urandom_range(1, 7));
                    else if (r < 92)
                        cnt = 4'd0;
                    else
                        cnt = 4'($urandom_range(9, 15));
                    start = (j == 0 && !carry_on) || ($urandom_range(0, 99) < 3);
                    send_word(rand64(), cnt, start);
                    carry_on = 1'b0;
                    sent++;
                end
            end
            wait_cipher_drain();
        end
    endtask

    // ---------------------------------------------------------------- sequence

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_zero_key_counts();
        test_extreme_keyset_boundary();
        test_message_restart();
        test_rekey_mid_message();
        test_random_messages();
        $display("Covered %0d words, %0d results checked, %0d key/nonce loads;",
                 words_sent, words_checked, keyset_loads);
        $display("byte counts 0 to 15, restarts, split blocks, mid-message rekeys, stalls.");
        if (err_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
